### sv/snc_pkg.sv
`default_nettype none
package snc_pkg;

  localparam int NEURONS   = 64;
  localparam int NIDX_W    = 6;
  localparam int EDGES     = 1024;
  localparam int EADDR_W   = 10;
  localparam int ECNT_W    = 11;
  localparam int SLOTS     = 8;
  localparam int SLOT_W    = 3;
  localparam int SADDR_W   = SLOT_W + NIDX_W;
  localparam int VAL_W     = 24;
  localparam int W_W       = 21;
  localparam int ACC_W     = 31;

  localparam logic [VAL_W-1:0] VAL_MAX   = 24'hFFFFFF;
  localparam logic [VAL_W-1:0] Q_ONE     = 24'd1048576;
  localparam logic [VAL_W-1:0] THR_LOW   = 24'd524288;
  localparam logic [VAL_W-1:0] THR_HIGH  = 24'd2097152;
  localparam logic [W_W-1:0]   W_CAP     = 21'd1572864;
  localparam logic [2:0]       REFRACT   = 3'd4;
  localparam logic [4:0]       WINDOW    = 5'd20;
  localparam logic [13:0]      RATE_STEP = 14'd10486;
  localparam logic [14:0]      HOMEO_GAIN = 15'd20972;
  localparam logic [31:0]      SEED      = 32'd123456789;
  localparam logic [23:0]      DIV5_MUL  = 24'd13421773;

  typedef enum logic [1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_PULSE    = 2'd1,
    OP_TICK     = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_LEAK     = 3'd0,
    CFG_RESET_V  = 3'd1,
    CFG_INHIBIT  = 3'd2,
    CFG_NOISE    = 3'd3,
    CFG_GAIN     = 3'd4,
    CFG_LTP      = 3'd5,
    CFG_LTD      = 3'd6,
    CFG_TARGET   = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_P_WR, ST_V_WAIT,
    ST_A_RD, ST_A_S1, ST_A_S2, ST_A_S3, ST_A_S4,
    ST_E_RD, ST_E_S1, ST_E_S2, ST_E_S3, ST_E_S4, ST_E_S5, ST_E_S6,
    ST_C_RD, ST_C_S1, ST_C_S2, ST_C_S3, ST_C_S4
  } st_t;

  typedef struct packed {
    logic [31:0]      spike_at;
    logic             seen;
    logic [2:0]       refr;
    logic [VAL_W-1:0] rate;
    logic [VAL_W-1:0] thr;
    logic [VAL_W-1:0] volt;
  } neuron_t;

  typedef struct packed {
    logic [SLOT_W-1:0] dly;
    logic [W_W-1:0]    w;
    logic [NIDX_W-1:0] dst;
    logic [NIDX_W-1:0] src;
  } edge_t;

  localparam neuron_t NRN_RESET = '{spike_at: 32'd0, seen: 1'b0, refr: 3'd0,
                                    rate: 24'd0, thr: Q_ONE, volt: 24'd0};

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
  endfunction

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage
`default_nettype wire

### sv/snc_ram.sv
`default_nettype none
module snc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/spiking_neuron_core_stdp.sv
// channel   | direction | handshake               | payload
// input     | in        | s_tvalid / s_tready     | s_tuser opcode, s_tdata operands
// result    | out       | m_tvalid / m_tready     | m_tdata fired mask, voltage, edges, flag
// config    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// add edge is answered straight from idle, pulse and read pass through ST_P_WR or ST_V_WAIT; a tick
// walks every neuron (A states), every stored edge (E states) and every neuron again (C states).
// after reset the delay slot memory is cleared entry by entry; s_tready stays low.
// one item at a time: s_tready is low until the previous result is taken.
`default_nettype none
module spiking_neuron_core_stdp (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // neuron_index, target_index, weight, delay, strength
  input  wire logic [1:0]   s_tuser,   // opcode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [103:0] m_tdata,   // fired_mask, voltage_value, edge_total, edge_accepted
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);

  snc_pkg::st_t state, state_next;

  logic [20:0] leak, amp, gain, ltp, ltd, target;
  logic [23:0] reset_v, inh;

  logic [31:0] tick, rnd;
  logic [10:0] edge_count;
  logic [63:0] fired;
  logic [30:0] inh_acc;
  logic [5:0]  idx;
  logic [9:0]  eidx;
  logic [8:0]  clr;
  logic [63:0] n_valid;
  logic [5:0]  n_rsel;

  logic [23:0] a_v0, a_v2;
  logic [20:0] a_noise;
  logic [24:0] a_drop;
  snc_pkg::neuron_t nw;
  snc_pkg::edge_t   ew;
  logic        sp_seen;
  logic [31:0] sp_at;
  logic [25:0] p_ltd, p_ltp;
  logic [21:0] q_ltd, q_ltp;
  logic [20:0] e_w1;
  logic [21:0] e_epsp;
  logic [8:0]  e_saddr;
  logic [23:0] p_str;
  logic [8:0]  p_addr;
  logic [23:0] c_v, c_r;
  logic [39:0] c_hp;
  logic        c_neg;

  logic [63:0] out_mask;
  logic [23:0] out_volt;
  logic [10:0] out_total;
  logic        out_acc;

  // memory ports
  logic        n_we;
  logic [5:0]  n_waddr, n_raddr;
  snc_pkg::neuron_t n_wdata, n_rdata, nq;
  logic        s_we;
  logic [8:0]  s_waddr, s_raddr;
  logic [23:0] s_wdata, s_rdata;
  logic        e_we;
  logic [9:0]  e_waddr, e_raddr;
  snc_pkg::edge_t e_wdata, e_rdata;

  snc_ram #(.WIDTH($bits(snc_pkg::neuron_t)), .DEPTH(snc_pkg::NEURONS)) u_nrn (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata));
  snc_ram #(.WIDTH(snc_pkg::VAL_W), .DEPTH(snc_pkg::SLOTS * snc_pkg::NEURONS)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
  snc_ram #(.WIDTH($bits(snc_pkg::edge_t)), .DEPTH(snc_pkg::EDGES)) u_edge (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));

  // input fields
  snc_pkg::op_t in_op;
  logic [5:0]  in_ni, in_ti;
  logic [20:0] in_w;
  logic [2:0]  in_dly;
  logic [23:0] in_str;
  logic        accept, edge_ok, last_n, last_e;

  assign in_op  = snc_pkg::op_t'(s_tuser);
  assign in_ni  = s_tdata[5:0];
  assign in_ti  = s_tdata[11:6];
  assign in_w   = s_tdata[32:12];
  assign in_dly = s_tdata[35:33];
  assign in_str = s_tdata[59:36];

  assign s_tready  = (state == snc_pkg::ST_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign edge_ok   = edge_count < 11'(snc_pkg::EDGES);
  assign last_n    = idx == 6'(snc_pkg::NEURONS - 1);
  assign last_e    = {1'b0, eidx} == edge_count - 11'd1;
  assign m_tdata   = {4'd0, out_acc, out_total, out_volt, out_mask};

  // combinational datapath
  logic [23:0] v1, v3, dd_th;
  logic signed [26:0] t_raw, th_raw;
  logic [31:0] rnd_next, dt_s, dt_d;
  logic        ok_ltd, ok_ltp, fs, fd;
  logic [21:0] w_sum;
  logic [20:0] w2;
  logic [24:0] r_raw;
  logic signed [25:0] err;
  logic [24:0] err_abs;
  logic [19:0] th_step;

  always_comb begin
    nq       = n_valid[n_rsel] ? n_rdata : snc_pkg::NRN_RESET;
    rnd_next = snc_pkg::xorshift(rnd);
    v1       = ({1'b0, a_v0} <= a_drop) ? 24'd0 : a_v0 - a_drop[23:0];
    t_raw    = $signed({3'b0, v1}) + $signed({6'b0, a_noise}) - $signed({7'b0, amp[20:1]});
    v3       = ({7'b0, a_v2} >= inh_acc) ? a_v2 - inh_acc[23:0] : 24'd0;
    fs       = fired[ew.src];
    fd       = fired[ew.dst];
    dt_s     = tick - sp_at;
    dt_d     = tick - nq.spike_at;
    ok_ltd   = fs && nq.seen && dt_d != 32'd0 && dt_d <= 32'(snc_pkg::WINDOW)
               && !(fd && ew.dst <= ew.src);
    ok_ltp   = fd && sp_seen && dt_s != 32'd0 && dt_s <= 32'(snc_pkg::WINDOW) && !fs;
    w_sum    = {1'b0, e_w1} + q_ltp;
    w2       = (fd && w_sum > {1'b0, snc_pkg::W_CAP}) ? snc_pkg::W_CAP : w_sum[20:0];
    r_raw    = {1'b0, nw.rate} - {7'b0, c_hp[37:20]}
               + (fired[idx] ? {11'b0, snc_pkg::RATE_STEP} : 25'd0);
    err      = $signed({2'b0, c_r}) - $signed({5'b0, target});
    err_abs  = err[25] ? 25'(-err) : err[24:0];
    th_step  = c_hp[39:20];
    th_raw   = c_neg ? $signed({3'b0, nw.thr}) - $signed({7'b0, th_step})
                     : $signed({3'b0, nw.thr}) + $signed({7'b0, th_step});
    if (th_raw < $signed({3'b0, snc_pkg::THR_LOW})) begin
      dd_th = snc_pkg::THR_LOW;
    end else if (th_raw > $signed({3'b0, snc_pkg::THR_HIGH})) begin
      dd_th = snc_pkg::THR_HIGH;
    end else begin
      dd_th = th_raw[23:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      snc_pkg::ST_CLEAR: if (clr == 9'(snc_pkg::SLOTS * snc_pkg::NEURONS - 1)) begin
        state_next = snc_pkg::ST_IDLE;
      end
      snc_pkg::ST_IDLE: if (accept) begin
        unique case (in_op)
          snc_pkg::OP_ADD_EDGE: state_next = snc_pkg::ST_IDLE;
          snc_pkg::OP_PULSE:    state_next = snc_pkg::ST_P_WR;
          snc_pkg::OP_TICK:     state_next = snc_pkg::ST_A_RD;
          snc_pkg::OP_READ:     state_next = snc_pkg::ST_V_WAIT;
        endcase
      end
      snc_pkg::ST_P_WR:   state_next = snc_pkg::ST_IDLE;
      snc_pkg::ST_V_WAIT: state_next = snc_pkg::ST_IDLE;
      snc_pkg::ST_A_RD:   state_next = snc_pkg::ST_A_S1;
      snc_pkg::ST_A_S1:   state_next = snc_pkg::ST_A_S2;
      snc_pkg::ST_A_S2:   state_next = snc_pkg::ST_A_S3;
      snc_pkg::ST_A_S3:   state_next = snc_pkg::ST_A_S4;
      snc_pkg::ST_A_S4: begin
        if (!last_n) begin
          state_next = snc_pkg::ST_A_RD;
        end else if (edge_count == 11'd0) begin
          state_next = snc_pkg::ST_C_RD;
        end else begin
          state_next = snc_pkg::ST_E_RD;
        end
      end
      snc_pkg::ST_E_RD:   state_next = snc_pkg::ST_E_S1;
      snc_pkg::ST_E_S1:   state_next = snc_pkg::ST_E_S2;
      snc_pkg::ST_E_S2:   state_next = snc_pkg::ST_E_S3;
      snc_pkg::ST_E_S3:   state_next = snc_pkg::ST_E_S4;
      snc_pkg::ST_E_S4:   state_next = snc_pkg::ST_E_S5;
      snc_pkg::ST_E_S5:   state_next = snc_pkg::ST_E_S6;
      snc_pkg::ST_E_S6:   state_next = last_e ? snc_pkg::ST_C_RD : snc_pkg::ST_E_RD;
      snc_pkg::ST_C_RD:   state_next = snc_pkg::ST_C_S1;
      snc_pkg::ST_C_S1:   state_next = snc_pkg::ST_C_S2;
      snc_pkg::ST_C_S2:   state_next = snc_pkg::ST_C_S3;
      snc_pkg::ST_C_S3:   state_next = snc_pkg::ST_C_S4;
      snc_pkg::ST_C_S4:   state_next = last_n ? snc_pkg::ST_IDLE : snc_pkg::ST_C_RD;
      default:            state_next = snc_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    n_we    = 1'b0;
    n_waddr = idx;
    n_wdata = nw;
    n_raddr = idx;
    s_we    = 1'b0;
    s_waddr = {tick[2:0], idx};
    s_wdata = 24'd0;
    s_raddr = {tick[2:0], idx};
    e_we    = 1'b0;
    e_waddr = eidx;
    e_wdata = ew;
    e_raddr = eidx;
    unique case (state)
      snc_pkg::ST_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr;
      end
      snc_pkg::ST_IDLE: begin
        n_raddr = in_ni;
        s_raddr = {tick[2:0], in_ni};
        e_we    = accept && in_op == snc_pkg::OP_ADD_EDGE && edge_ok;
        e_waddr = edge_count[9:0];
        e_wdata = '{dly: in_dly, w: in_w, dst: in_ti, src: in_ni};
      end
      snc_pkg::ST_P_WR: begin
        s_we    = 1'b1;
        s_waddr = p_addr;
        s_wdata = snc_pkg::sat_add(s_rdata, p_str);
      end
      snc_pkg::ST_A_S1: s_we = 1'b1;
      snc_pkg::ST_A_S4: begin
        n_we = 1'b1;
        if (nw.refr <= 3'd1 && v3 >= nw.thr) begin
          n_wdata.volt = reset_v;
          n_wdata.refr = snc_pkg::REFRACT;
        end else begin
          n_wdata.volt = v3;
          n_wdata.refr = (nw.refr == 3'd0) ? 3'd0 : nw.refr - 3'd1;
        end
      end
      snc_pkg::ST_E_S1: n_raddr = e_rdata.src;
      snc_pkg::ST_E_S2: n_raddr = ew.dst;
      snc_pkg::ST_E_S5: s_raddr = {tick[2:0] + ew.dly, ew.dst};
      snc_pkg::ST_E_S6: begin
        s_we    = fs;
        s_waddr = e_saddr;
        s_wdata = snc_pkg::sat_add(s_rdata, {2'b0, e_epsp});
        e_we    = 1'b1;
        e_wdata.w = w2;
      end
      snc_pkg::ST_C_S4: begin
        n_we         = 1'b1;
        n_wdata.volt = c_v;
        n_wdata.rate = c_r;
        n_wdata.thr  = dd_th;
        if (fired[idx]) begin
          n_wdata.seen     = 1'b1;
          n_wdata.spike_at = tick;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= snc_pkg::ST_CLEAR;
      clr        <= 9'd0;
      tick       <= 32'd0;
      rnd        <= snc_pkg::SEED;
      edge_count <= 11'd0;
      idx        <= 6'd0;
      eidx       <= 10'd0;
      n_valid    <= 64'd0;
      m_tvalid   <= 1'b0;
      leak       <= 21'd20972;
      reset_v    <= 24'd209715;
      inh        <= 24'd62915;
      amp        <= 21'd20972;
      gain       <= 21'd524288;
      ltp        <= 21'd10486;
      ltd        <= 21'd12583;
      target     <= 21'd52429;
    end else begin
      state <= state_next;
      if (state == snc_pkg::ST_CLEAR) begin
        clr <= clr + 9'd1;
      end
      if (n_we) begin
        n_valid[n_waddr] <= 1'b1;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (snc_pkg::cfg_idx_t'(cfg_index))
          snc_pkg::CFG_LEAK:    leak    <= cfg_data[20:0];
          snc_pkg::CFG_RESET_V: reset_v <= cfg_data;
          snc_pkg::CFG_INHIBIT: inh     <= cfg_data;
          snc_pkg::CFG_NOISE:   amp     <= cfg_data[20:0];
          snc_pkg::CFG_GAIN:    gain    <= cfg_data[20:0];
          snc_pkg::CFG_LTP:     ltp     <= cfg_data[20:0];
          snc_pkg::CFG_LTD:     ltd     <= cfg_data[20:0];
          snc_pkg::CFG_TARGET:  target  <= cfg_data[20:0];
        endcase
      end
      unique case (state)
        snc_pkg::ST_IDLE: if (accept && in_op == snc_pkg::OP_ADD_EDGE) begin
          m_tvalid <= 1'b1;
          if (edge_ok) begin
            edge_count <= edge_count + 11'd1;
          end
        end
        snc_pkg::ST_P_WR, snc_pkg::ST_V_WAIT: m_tvalid <= 1'b1;
        snc_pkg::ST_A_S1: rnd <= rnd_next;
        snc_pkg::ST_A_S4: begin
          idx  <= idx + 6'd1;
          eidx <= 10'd0;
        end
        snc_pkg::ST_E_S6: eidx <= eidx + 10'd1;
        snc_pkg::ST_C_S4: begin
          idx <= idx + 6'd1;
          if (last_n) begin
            tick     <= tick + 32'd1;
            m_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_rsel <= n_raddr;
    unique case (state)
      snc_pkg::ST_IDLE: if (accept) begin
        p_str     <= in_str;
        p_addr    <= {tick[2:0], in_ni};
        out_mask  <= 64'd0;
        out_volt  <= 24'd0;
        out_acc   <= in_op == snc_pkg::OP_ADD_EDGE && edge_ok;
        out_total <= edge_count + {10'd0, in_op == snc_pkg::OP_ADD_EDGE && edge_ok};
        inh_acc   <= 31'd0;
        fired     <= 64'd0;
      end
      snc_pkg::ST_P_WR:   out_total <= edge_count;
      snc_pkg::ST_V_WAIT: begin
        out_volt  <= nq.volt;
        out_total <= edge_count;
      end
      snc_pkg::ST_A_S1: begin
        nw      <= nq;
        a_v0    <= snc_pkg::sat_add(nq.volt, s_rdata);
        a_noise <= 21'((45'(amp) * 45'(rnd_next[23:0])) >> 24);
      end
      snc_pkg::ST_A_S2: a_drop <= 25'((45'(a_v0) * 45'(leak)) >> 20);
      snc_pkg::ST_A_S3: begin
        if (t_raw < 27'sd0) begin
          a_v2 <= 24'd0;
        end else if (t_raw > $signed({3'b0, snc_pkg::VAL_MAX})) begin
          a_v2 <= snc_pkg::VAL_MAX;
        end else begin
          a_v2 <= t_raw[23:0];
        end
      end
      snc_pkg::ST_A_S4: if (nw.refr <= 3'd1 && v3 >= nw.thr) begin
        fired[idx] <= 1'b1;
        inh_acc    <= inh_acc + {7'd0, inh};
      end
      snc_pkg::ST_E_S1: ew <= e_rdata;
      snc_pkg::ST_E_S2: begin
        sp_seen <= nq.seen;
        sp_at   <= nq.spike_at;
      end
      snc_pkg::ST_E_S3: begin
        p_ltd <= ok_ltd ? 26'(ltd) * 26'(snc_pkg::WINDOW - dt_d[4:0]) : 26'd0;
        p_ltp <= ok_ltp ? 26'(ltp) * 26'(snc_pkg::WINDOW - dt_s[4:0]) : 26'd0;
      end
      snc_pkg::ST_E_S4: begin
        q_ltd <= 22'((48'(p_ltd[25:2]) * 48'(snc_pkg::DIV5_MUL)) >> 26);
        q_ltp <= 22'((48'(p_ltp[25:2]) * 48'(snc_pkg::DIV5_MUL)) >> 26);
      end
      snc_pkg::ST_E_S5: begin
        e_w1    <= ({1'b0, ew.w} > q_ltd) ? ew.w - q_ltd[20:0] : 21'd0;
        e_epsp  <= 22'((42'(({1'b0, ew.w} > q_ltd) ? ew.w - q_ltd[20:0] : 21'd0)
                        * 42'(gain)) >> 20);
        e_saddr <= {tick[2:0] + ew.dly, ew.dst};
      end
      snc_pkg::ST_C_S1: begin
        nw   <= nq;
        c_hp <= 40'(nq.rate) * 40'(snc_pkg::RATE_STEP);
        if (fired[idx]) begin
          inh_acc <= inh_acc - {7'd0, inh};
        end
      end
      snc_pkg::ST_C_S2: begin
        c_v <= ({7'd0, nw.volt} >= inh_acc) ? nw.volt - inh_acc[23:0] : 24'd0;
        c_r <= r_raw[24] ? snc_pkg::VAL_MAX : r_raw[23:0];
      end
      snc_pkg::ST_C_S3: begin
        c_hp  <= 40'(err_abs) * 40'(snc_pkg::HOMEO_GAIN);
        c_neg <= err[25];
      end
      snc_pkg::ST_C_S4: if (last_n) begin
        out_mask  <= fired;
        out_volt  <= 24'd0;
        out_acc   <= 1'b0;
        out_total <= edge_count;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/snc_checker.sv
`default_nettype none
module snc_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [103:0] m_tdata
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one transaction in flight
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[98:88] <= 11'd1024)
    else $error("edge count beyond table");

  a_acc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[99] |-> m_tdata[87:0] == 88'd0)
    else $error("stored edge with tick or read data");

endmodule

bind spiking_neuron_core_stdp snc_checker u_snc_checker (.*);
`default_nettype wire
